// ----- src/xsd_pkg.sv -----
`default_nettype none

package xsd_pkg;

    localparam int ROW_BITS  = 64;
    localparam int LANES     = 8;
    localparam int SUM_W     = 7;
    localparam int SPRITE_W  = 120;

    typedef struct packed {
        logic [ROW_BITS-1:0] mask;
        logic                hit;
    } lane_out_t;

endpackage

`default_nettype wire

// ----- src/xsd_ram.sv -----
`default_nettype none

module xsd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/xsd_lane.sv -----
`default_nettype none

module xsd_lane
    import xsd_pkg::*;
#(
    parameter int FRAME_WIDTH = 64,
    parameter int LANE        = 0
) (
    input  wire logic                pix_bit,
    input  wire logic [5:0]          x_col,
    input  wire logic [ROW_BITS-1:0] old_row,
    output lane_out_t                lane_out
);

    logic [SUM_W-1:0] col;
    logic             on;

    assign col = SUM_W'(x_col) + SUM_W'(LANE);
    assign on  = pix_bit && (col < SUM_W'(FRAME_WIDTH));

    assign lane_out.mask = on ? (ROW_BITS'(1) << col[5:0]) : '0;
    assign lane_out.hit  = on && old_row[col[5:0]];

endmodule

`default_nettype wire

// ----- src/xsd_merge.sv -----
`default_nettype none

module xsd_merge
    import xsd_pkg::*;
(
    input  wire lane_out_t           lanes [LANES],
    input  wire logic [ROW_BITS-1:0] old_row,
    output logic      [ROW_BITS-1:0] new_row,
    output logic                     hit
);

    logic [ROW_BITS-1:0] toggle;

    always_comb begin
        toggle = '0;
        hit    = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            toggle = toggle | lanes[i].mask;
            hit    = hit | lanes[i].hit;
        end
        new_row = old_row ^ toggle;
    end

endmodule

`default_nettype wire

// ----- src/xor_sprite_draw_collision_core.sv -----
// A draw does one read-modify-write of a frame row per cycle through the RAM's registered
// read port; a read fetches its row through the same port. Each result goes to the output
// register, and the next item is taken while the previous result waits in the output
// register.
// Reset: synchronous active-low; per-row valid flags clear, so the whole frame reads dark.
`default_nettype none

module xor_sprite_draw_collision_core
    import xsd_pkg::*;
#(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // x_pos[7:0], y_pos[15:8], rows_used[19:16], sprite_rows_lo[83:20],
    // sprite_rows_hi[139:84], read_row[144:140], zero pad[151:145]
    input  wire logic [151:0] s_tdata,
    // cmd[0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // row_pixels[63:0]
    output logic [63:0]       m_tdata,
    // collision[0]
    output logic              m_tuser
);

    localparam int AW = $clog2(FRAME_HEIGHT);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    function automatic logic [7:0] mod_reduce(input logic [7:0] v, input logic [10:0] m);
        logic [10:0] acc;
        acc = {3'b000, v};
        for (int k = 4; k >= 0; k--) begin
            if (acc >= (m << k)) begin
                acc = acc - (m << k);
            end
        end
        return acc[7:0];
    endfunction

    state_t                state_reg, state_next;
    logic                  is_read_reg;
    logic                  rd_ok_reg;
    logic [5:0]            x_col_reg;
    logic [AW-1:0]         y_row_reg;
    logic [3:0]            height_reg;
    logic [3:0]            cnt_reg;
    logic [SPRITE_W-1:0]   sprite_reg;
    logic [4:0]            read_row_reg;
    logic                  s1_valid_reg;
    logic                  s1_read_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic [LANES-1:0]      s1_byte_reg;
    logic                  valid_rd_reg;
    logic [FRAME_HEIGHT-1:0] row_valid_reg;
    logic                  hit_reg;
    logic [ROW_BITS-1:0]   row_out_reg;
    logic                  m_valid_reg;
    logic                  m_collision_reg;
    logic [ROW_BITS-1:0]   m_row_reg;

    logic                  accept;
    logic                  issue_go;
    logic                  out_load;
    logic [SUM_W-1:0]      row_sum;
    logic [AW-1:0]         raddr;
    logic                  ram_we;
    logic [ROW_BITS-1:0]   ram_rdata;
    logic [ROW_BITS-1:0]   old_row;
    logic [ROW_BITS-1:0]   new_row;
    logic                  row_hit;
    lane_out_t             lane_res [LANES];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign row_sum  = SUM_W'(y_row_reg) + SUM_W'(cnt_reg);
    assign issue_go = (state_reg == ST_RUN) &&
                      (is_read_reg ? (cnt_reg == 4'd0)
                                   : ((cnt_reg < height_reg) &&
                                      (row_sum < SUM_W'(FRAME_HEIGHT))));
    assign raddr    = is_read_reg ? AW'(read_row_reg) : row_sum[AW-1:0];
    assign ram_we   = s1_valid_reg && !s1_read_reg;
    assign old_row  = valid_rd_reg ? ram_rdata : '0;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    xsd_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (FRAME_HEIGHT)
    ) u_frame (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (new_row),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    for (genvar b = 0; b < LANES; b++) begin : g_lane
        xsd_lane #(
            .FRAME_WIDTH (FRAME_WIDTH),
            .LANE        (b)
        ) u_lane (
            .pix_bit  (s1_byte_reg[LANES-1-b]),
            .x_col    (x_col_reg),
            .old_row  (old_row),
            .lane_out (lane_res[b])
        );
    end

    xsd_merge u_merge (
        .lanes   (lane_res),
        .old_row (old_row),
        .new_row (new_row),
        .hit     (row_hit)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!issue_go && !s1_valid_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
        end else begin
            state_reg    <= state_next;
            s1_valid_reg <= issue_go;
            if (ram_we) begin
                row_valid_reg[s1_addr_reg] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            is_read_reg  <= s_tuser;
            x_col_reg    <= 6'(mod_reduce(s_tdata[7:0], 11'(FRAME_WIDTH)));
            y_row_reg    <= AW'(mod_reduce(s_tdata[15:8], 11'(FRAME_HEIGHT)));
            height_reg   <= s_tdata[19:16];
            sprite_reg   <= s_tdata[139:20];
            read_row_reg <= s_tdata[144:140];
            rd_ok_reg    <= (SUM_W'(s_tdata[144:140]) < SUM_W'(FRAME_HEIGHT));
            cnt_reg      <= '0;
            hit_reg      <= 1'b0;
        end else begin
            if (issue_go) begin
                cnt_reg    <= cnt_reg + 4'd1;
                sprite_reg <= sprite_reg >> LANES;
            end
            if (ram_we && row_hit) begin
                hit_reg <= 1'b1;
            end
        end
        if (issue_go) begin
            s1_read_reg  <= is_read_reg;
            s1_addr_reg  <= raddr;
            s1_byte_reg  <= sprite_reg[LANES-1:0];
            valid_rd_reg <= row_valid_reg[raddr];
        end
        if (s1_valid_reg && s1_read_reg) begin
            row_out_reg <= rd_ok_reg ? old_row : '0;
        end
        if (out_load) begin
            m_collision_reg <= is_read_reg ? 1'b0 : hit_reg;
            m_row_reg       <= is_read_reg ? row_out_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_row_reg;
    assign m_tuser  = m_collision_reg;

    a_ready_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !s1_valid_reg)
        else $error("input ready while a row is still in flight");

    a_write_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_RUN))
        else $error("frame write outside of a draw");

    a_read_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_row_reg != '0)) |-> !m_collision_reg)
        else $error("row data and collision flag both set");

endmodule

`default_nettype wire

// ----- tb/tb_xor_sprite_draw_collision_core.sv -----
`default_nettype none

module tb_xor_sprite_draw_collision_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_W       = 64;
    localparam int FRAME_H       = 32;
    localparam int PHASE_ITEMS   = 310;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum bit {
        CMD_DRAW = 1'b0,
        CMD_READ = 1'b1
    } sprite_op_e;

    typedef struct packed {
        sprite_op_e  cmd;
        logic [7:0]  x_pos;
        logic [7:0]  y_pos;
        logic [3:0]  rows_used;
        logic [63:0] sprite_lo;
        logic [55:0] sprite_hi;
        logic [4:0]  read_row;
    } sprite_cmd_t;

    typedef struct packed {
        logic        collision;
        logic [63:0] row_pixels;
    } frame_reply_t;

    class frame_scoreboard;
        logic [63:0]  frame_rows [FRAME_H];
        frame_reply_t pending_replies [$];
        int           errors;
        int           draws;
        int           reads;
        int           hits;
        int           clipped;

        function new();
            foreach (frame_rows[i]) frame_rows[i] = '0;
            errors  = 0;
            draws   = 0;
            reads   = 0;
            hits    = 0;
            clipped = 0;
        endfunction

        function void note_command(sprite_cmd_t c);
            frame_reply_t r;
            int           col0;
            int           row0;
            int           row;
            logic [7:0]   bits;
            bit           hit;
            bit           clip;
            r    = '0;
            hit  = 1'b0;
            clip = 1'b0;
            if (c.cmd == CMD_DRAW) begin
                col0 = c.x_pos % FRAME_W;
                row0 = c.y_pos % FRAME_H;
                for (int k = 0; k < c.rows_used; k++) begin
                    row = row0 + k;
                    if (row >= FRAME_H) begin
                        clip = 1'b1;
                        break;
                    end
                    if (k < 8) begin
                        bits = c.sprite_lo[8*k +: 8];
                    end else begin
                        bits = c.sprite_hi[8*(k-8) +: 8];
                    end
                    for (int b = 0; b < 8; b++) begin
                        if (bits[7-b]) begin
                            if (col0 + b >= FRAME_W) begin
                                clip = 1'b1;
                            end else begin
                                if (frame_rows[row][col0+b]) hit = 1'b1;
                                frame_rows[row][col0+b] = ~frame_rows[row][col0+b];
                            end
                        end
                    end
                end
                r.collision = hit;
                draws++;
                hits    += hit;
                clipped += clip;
            end else begin
                if (c.read_row < FRAME_H) r.row_pixels = frame_rows[c.read_row];
                reads++;
            end
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic collision, logic [63:0] row_pixels, realtime t);
            frame_reply_t e;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected result collision=%0b row_pixels=%h",
                         t, collision, row_pixels);
                return;
            end
            e = pending_replies.pop_front();
            if (collision !== e.collision) begin
                errors++;
                $display("%0t: collision mismatch, expected %0b, actual %0b",
                         t, e.collision, collision);
            end
            if (row_pixels !== e.row_pixels) begin
                errors++;
                $display("%0t: row_pixels mismatch, expected %h, actual %h",
                         t, e.row_pixels, row_pixels);
            end
        endfunction

        function int pending_count();
            return pending_replies.size();
        endfunction
    endclass

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;

    frame_scoreboard sb = new();
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              hold_left      = 0;
    int              cycle_count    = 0;
    sprite_cmd_t     last_draw;

    xor_sprite_draw_collision_core #(
        .FRAME_WIDTH (FRAME_W),
        .FRAME_HEIGHT(FRAME_H)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_reply(m_tuser, m_tdata, $realtime);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending_count());
        $display("Verification failed");
        $finish;
    end

    function automatic sprite_cmd_t draw_cmd(logic [7:0] x, logic [7:0] y, logic [3:0] h,
                                             logic [63:0] lo, logic [55:0] hi);
        sprite_cmd_t c;
        c           = '0;
        c.cmd       = CMD_DRAW;
        c.x_pos     = x;
        c.y_pos     = y;
        c.rows_used = h;
        c.sprite_lo = lo;
        c.sprite_hi = hi;
        c.read_row  = 5'($urandom);
        return c;
    endfunction

    function automatic sprite_cmd_t read_cmd(logic [4:0] row);
        sprite_cmd_t c;
        c           = '0;
        c.cmd       = CMD_READ;
        c.x_pos     = 8'($urandom);
        c.y_pos     = 8'($urandom);
        c.rows_used = 4'($urandom);
        c.sprite_lo = {$urandom, $urandom};
        c.sprite_hi = 56'({$urandom, $urandom});
        c.read_row  = row;
        return c;
    endfunction

    function automatic sprite_cmd_t random_cmd();
        sprite_cmd_t c;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            c = read_cmd(5'($urandom));
        end else if (pick < 45 && last_draw.cmd == CMD_DRAW) begin
            // redraw the previous sprite; XOR toggles its pixels again, so it collides wherever they are lit
            c = last_draw;
        end else begin
            c = draw_cmd(8'($urandom), 8'($urandom),
                         ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom),
                         {$urandom, $urandom}, 56'({$urandom, $urandom}));
            last_draw = c;
        end
        return c;
    endfunction

    task automatic send_item(input sprite_cmd_t c);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= {7'd0, c.read_row, c.sprite_hi, c.sprite_lo, c.rows_used,
                     c.y_pos, c.x_pos};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(c);
    endtask

    task automatic wait_drained();
        while (sb.pending_count() != 0) @(posedge aclk);
    endtask

    initial begin
        last_draw     = '0;
        last_draw.cmd = CMD_READ;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(read_cmd(5'd0));
        send_item(read_cmd(5'd31));
        send_item(draw_cmd(8'd0, 8'd0, 4'd0, '1, '1));
        send_item(read_cmd(5'd0));
        send_item(draw_cmd(8'd0, 8'd0, 4'd15, '1, '1));
        send_item(read_cmd(5'd14));
        send_item(draw_cmd(8'd0, 8'd0, 4'd15, '1, '1));
        send_item(read_cmd(5'd0));
        send_item(draw_cmd(8'd255, 8'd255, 4'd15, '1, '1));
        send_item(read_cmd(5'd31));
        send_item(draw_cmd(8'd60, 8'd20, 4'd15, {8{8'hAA}}, {7{8'h55}}));
        send_item(read_cmd(5'd20));
        send_item(read_cmd(5'd31));
        send_item(draw_cmd(8'd128, 8'd64, 4'd1, 64'h80, '0));
        send_item(read_cmd(5'd0));
        send_item(draw_cmd(8'd191, 8'd159, 4'd8, 64'h0102040810204080, '0));
        send_item(draw_cmd(8'd63, 8'd31, 4'd1, 64'h01, '0));
        send_item(read_cmd(5'd31));
        send_item(draw_cmd(8'd56, 8'd17, 4'd15, '0, {7{8'hFF}}));
        send_item(read_cmd(5'd25));
        s_tvalid <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // hold the output off while items keep coming, so the input backs up
                if (i == PHASE_ITEMS / 2 && phase != 1) hold_left = HOLD_CYCLES;
                send_item(random_cmd());
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d sprite draws (%0d colliding, %0d clipped at an edge) and %0d row reads,",
                 sb.draws, sb.hits, sb.clipped, sb.reads);
        $display("across free-running, sender-idle, receiver-stall and mixed pacing with output hold-off.");
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
